// ===== src/signed_decimal_formatter_unit_defines.svh =====
// Assertion macros used by the signed decimal formatter top level.
`ifndef SIGNED_DECIMAL_FORMATTER_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sdf_pkg.sv =====
// Types, constants and control store of the signed decimal formatter.
`default_nettype none

package sdf_pkg;

   localparam int MAX_FIELD_DEFAULT = 32;
   localparam int CALC_W = 7;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W = 4 * BCD_DIGITS;
   localparam int STEP_W = 3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_BLANK = 8'h20;

   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               plus_flag;
      logic               blank_flag;
      logic               zero_pad;
      logic [5:0]         field_width;
      logic [4:0]         min_digits;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CONV,
      OP_NORM,
      OP_SIZE,
      OP_SIGN,
      OP_ZERO,
      OP_DIGIT,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_BITS_LEFT,
      COND_NORM_MORE,
      COND_SIGN_WAIT,
      COND_ZERO_MORE,
      COND_DIGIT_MORE
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_go;
      logic bits_left;
      logic norm_more;
      logic sign_wait;
      logic zeros_more;
      logic digits_more;
   } dp_status_type;

   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CONV  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_NORM  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SIZE  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SIGN  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ZERO  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_DIGIT = 3'd6;
   localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] addr);
      ctrl_word_type cw;
      case (addr)
         STEP_IDLE:  cw = '{op: OP_IDLE,  cond: COND_NO_REQ,     target: STEP_IDLE};
         STEP_CONV:  cw = '{op: OP_CONV,  cond: COND_BITS_LEFT,  target: STEP_CONV};
         STEP_NORM:  cw = '{op: OP_NORM,  cond: COND_NORM_MORE,  target: STEP_NORM};
         STEP_SIZE:  cw = '{op: OP_SIZE,  cond: COND_NEVER,      target: STEP_IDLE};
         STEP_SIGN:  cw = '{op: OP_SIGN,  cond: COND_SIGN_WAIT,  target: STEP_SIGN};
         STEP_ZERO:  cw = '{op: OP_ZERO,  cond: COND_ZERO_MORE,  target: STEP_ZERO};
         STEP_DIGIT: cw = '{op: OP_DIGIT, cond: COND_DIGIT_MORE, target: STEP_DIGIT};
         STEP_DONE:  cw = '{op: OP_NOP,   cond: COND_ALWAYS,     target: STEP_IDLE};
         default:    cw = '{op: OP_NOP,   cond: COND_ALWAYS,     target: STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ===== src/sdf_sequencer.sv =====
// Step counter and control store lookup with conditional jumps.
`default_nettype none

module sdf_sequencer
   import sdf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_status_type     status,
   output ctrl_word_type          ctrl,
   output logic [STEP_W-1:0]      step
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              take_jump;

   assign ctrl = ucode_rom(pc_ff);
   assign step = pc_ff;

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:      take_jump = 1'b0;
         COND_ALWAYS:     take_jump = 1'b1;
         COND_NO_REQ:     take_jump = !status.req_go;
         COND_BITS_LEFT:  take_jump = status.bits_left;
         COND_NORM_MORE:  take_jump = status.norm_more;
         COND_SIGN_WAIT:  take_jump = status.sign_wait;
         COND_ZERO_MORE:  take_jump = status.zeros_more;
         COND_DIGIT_MORE: take_jump = status.digits_more;
         default:         take_jump = 1'b1;
      endcase
      pc_in = take_jump ? ctrl.target : pc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/sdf_datapath.sv =====
// Magnitude, BCD digit, length and character registers driven by the control word.
`default_nettype none

module sdf_datapath
   import sdf_pkg::*;
#(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
)
(
   input  wire logic          clock,
   input  wire op_type        op,
   input  wire logic          accept,
   input  wire req_word_type  req_word,
   input  wire logic          out_free,
   output dp_status_type      status,
   output logic               emit,
   output rsp_word_type       emit_word
);

   localparam int LEN_W = $clog2(MAX_FIELD + 1);

   logic [31:0]       mag_ff,      mag_in;
   logic [BCD_W-1:0]  bcd_ff,      bcd_in;
   logic [4:0]        bit_cnt_ff,  bit_cnt_in;
   logic [3:0]        ndig_ff,     ndig_in;
   logic              has_sign_ff, has_sign_in;
   logic [7:0]        sign_ff,     sign_in;
   logic [4:0]        prec_ff,     prec_in;
   logic              zp_ff,       zp_in;
   logic [5:0]        width_ff,    width_in;
   logic [LEN_W-1:0]  zeros_ff,    zeros_in;

   logic [BCD_W-1:0]  bcd_adj;
   logic              is_neg;
   logic              is_min;
   logic [CALC_W-1:0] len_digits;
   logic [CALC_W-1:0] len_prec;
   logic [CALC_W-1:0] len_width;
   logic [CALC_W-1:0] len_max;
   logic [CALC_W-1:0] len_cap;
   logic [3:0]        top_digit;

   assign is_neg    = req_word.value[31];
   assign is_min    = req_word.value == MOST_NEGATIVE;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      len_digits = CALC_W'(ndig_ff) + CALC_W'(has_sign_ff);
      len_prec   = CALC_W'(prec_ff) + CALC_W'(has_sign_ff);
      len_width  = zp_ff ? CALC_W'(width_ff) : '0;
      len_max    = len_digits;
      if (len_prec > len_max) begin
         len_max = len_prec;
      end
      if (len_width > len_max) begin
         len_max = len_width;
      end
      len_cap = (len_max > CALC_W'(MAX_FIELD)) ? CALC_W'(MAX_FIELD) : len_max;
   end

   always_comb begin
      status.req_go      = accept;
      status.bits_left   = bit_cnt_ff != '0;
      status.norm_more   = (top_digit == 4'd0) && (ndig_ff > 4'd1);
      status.sign_wait   = has_sign_ff && !out_free;
      status.zeros_more  = zeros_ff != '0;
      status.digits_more = !(out_free && (ndig_ff == 4'd1));
   end

   always_comb begin
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      bit_cnt_in  = bit_cnt_ff;
      ndig_in     = ndig_ff;
      has_sign_in = has_sign_ff;
      sign_in     = sign_ff;
      prec_in     = prec_ff;
      zp_in       = zp_ff;
      width_in    = width_ff;
      zeros_in    = zeros_ff;
      emit        = 1'b0;
      emit_word   = '{out_char: CHAR_ZERO, last: 1'b0};
      case (op)
         OP_IDLE: begin
            if (accept) begin
               mag_in      = is_neg ? 32'(0) - 32'(req_word.value) : 32'(req_word.value);
               bcd_in      = '0;
               bit_cnt_in  = 5'd31;
               ndig_in     = 4'(BCD_DIGITS);
               has_sign_in = is_neg || req_word.blank_flag || req_word.plus_flag;
               sign_in     = is_neg ? CHAR_MINUS
                           : (req_word.blank_flag ? CHAR_BLANK : CHAR_PLUS);
               prec_in     = is_min ? 5'd0 : req_word.min_digits;
               zp_in       = is_min ? 1'b0 : req_word.zero_pad;
               width_in    = req_word.field_width;
            end
         end
         OP_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[31]};
            mag_in     = {mag_ff[30:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 5'd1;
         end
         OP_NORM: begin
            if (status.norm_more) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - 4'd1;
            end
         end
         OP_SIZE: begin
            zeros_in = LEN_W'(len_cap - len_digits);
         end
         OP_SIGN: begin
            if (has_sign_ff && out_free) begin
               emit      = 1'b1;
               emit_word = '{out_char: sign_ff, last: 1'b0};
            end
         end
         OP_ZERO: begin
            if ((zeros_ff != '0) && out_free) begin
               emit      = 1'b1;
               emit_word = '{out_char: CHAR_ZERO, last: 1'b0};
               zeros_in  = zeros_ff - LEN_W'(1);
            end
         end
         OP_DIGIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_word = '{out_char: CHAR_ZERO + {4'd0, top_digit},
                             last: ndig_ff == 4'd1};
               bcd_in    = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in   = ndig_ff - 4'd1;
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      ndig_ff     <= ndig_in;
      has_sign_ff <= has_sign_in;
      sign_ff     <= sign_in;
      prec_ff     <= prec_in;
      zp_ff       <= zp_in;
      width_ff    <= width_in;
      zeros_ff    <= zeros_in;
   end

endmodule

`default_nettype wire

// ===== src/signed_decimal_formatter_unit.sv =====
// Top level of the signed decimal formatter: sequencer, datapath and output register.
//
// Usage:
//   req channel (req_valid, req_stall, req_word) takes one signed 32-bit value with
//   plus, blank and zero-pad flags, a field width and a precision. req_stall stays
//   high from acceptance until the last character of that value has been produced.
//   rsp channel (rsp_valid, rsp_stall, rsp_word) returns the ASCII text one character
//   per word, most significant first; last marks the final character.
// Timing:
//   A shift-and-add-3 loop of 32 steps converts the magnitude, then a normalize loop
//   drops leading zero digits and a size step counts the pad zeros. The sign, the pad
//   zeros and the digits then leave through the output register one per cycle while
//   rsp is not stalled, with an empty zero step before the first digit when a sign or
//   pad zeros precede it.
// Stall:
//   A stalled rsp holds its word in the output register; the program waits at its
//   current emitting step until the register frees up.
// Reset:
//   Synchronous, active high. Returns to the idle step and empties the output register.
`default_nettype none

`include "signed_decimal_formatter_unit_defines.svh"

module signed_decimal_formatter_unit
   import sdf_pkg::*;
#(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_word_type  req_word,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_word_type       rsp_word
);

   ctrl_word_type     ctrl;
   logic [STEP_W-1:0] step;
   dp_status_type     status;
   logic              accept;
   logic              out_free;
   logic              emit;
   rsp_word_type      emit_word;
   logic              emit_last;
   logic              out_step;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff,  rsp_word_in;

   assign req_stall = step != STEP_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sdf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   sdf_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_dp (
      .clock     (clock),
      .op        (ctrl.op),
      .accept    (accept),
      .req_word  (req_word),
      .out_free  (out_free),
      .status    (status),
      .emit      (emit),
      .emit_word (emit_word)
   );

   always_comb begin
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_word_in  = emit ? emit_word : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign emit_last = emit && emit_word.last;
   assign out_step  = step == STEP_SIGN || step == STEP_ZERO || step == STEP_DIGIT;

   `SDF_ASSERT_NOW(a_emit_into_free, emit, out_free, "emit into full output register")
   `SDF_ASSERT_NEXT(a_accept_leaves_idle, accept, step == STEP_CONV, "no start after accept")
   `SDF_ASSERT_NOW(a_last_from_digit, emit_last, step == STEP_DIGIT, "last outside digit step")
   `SDF_ASSERT_NOW(a_emit_only_output_steps, emit, out_step, "emit outside output step")

endmodule

`default_nettype wire
